// ----- design/hslp_pkg.sv -----
// Shared types and constants for the color sample to HSL converter.
// No dependencies; used by every module in this folder except hslp_divider.
package hslp_pkg;

   localparam int CNT_W       = 16;  // sensor count width
   localparam int PCT_W       = 7;   // percent value width
   localparam int HUE_W       = 9;   // hue in degrees
   localparam int SCALED_W    = 23;  // count * 100
   localparam int RATIO_NUM_W = 14;  // hue / saturation numerators
   localparam int RATIO_DEN_W = 8;   // hue / saturation divisors
   localparam int DIV_STEPS   = 2;   // quotient bits per divider stage

   localparam int PCT_FULL   = 100;
   localparam int HUE_STEP   = 60;
   localparam int HUE_FULL   = 360;
   localparam int HUE_GREEN  = 120;
   localparam int HUE_BLUE   = 240;
   localparam int SUM_FULL   = 200;
   localparam int LIGHT_HALF = 50;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } hue_sector_type;

   // Sideband through the percent divider
   typedef struct packed {
      logic       zero;
      logic [2:0] ovf;   // quotient >= 128, saturate
   } pct_sb_type;

   // Control that rides along with the hue / saturation division
   typedef struct packed {
      logic                 zero;
      logic                 grey;
      logic                 neg;
      hue_sector_type       sector;
      logic [PCT_W-1:0]     lightness;
   } hue_ctl_type;

endpackage

// ----- design/hslp_divider.sv -----
// Pipelined restoring divider, several lanes in lockstep, sideband carried along.
// Uses no package items; instantiated by the top level.
module hslp_divider #(
   parameter int LANES = 1,
   parameter int NUM_W = 8,
   parameter int DEN_W = 8,
   parameter int Q_W   = 8,
   parameter int SB_W  = 1,
   parameter int STEPS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num [LANES],
   input  logic [DEN_W-1:0] in_den [LANES],
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo [LANES],
   output logic [SB_W-1:0]  out_sb
);

   localparam int STAGES = (Q_W + STEPS - 1) / STEPS;
   localparam int EXT_W  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + Q_W;

   logic             valid_ff [STAGES];
   logic [NUM_W-1:0] rem_ff   [STAGES][LANES];
   logic [DEN_W-1:0] den_ff   [STAGES][LANES];
   logic [Q_W-1:0]   quo_ff   [STAGES][LANES];
   logic [SB_W-1:0]  sb_ff    [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic             v_src;
      logic [NUM_W-1:0] rem_src [LANES];
      logic [DEN_W-1:0] den_src [LANES];
      logic [Q_W-1:0]   quo_src [LANES];
      logic [SB_W-1:0]  sb_src;
      logic [NUM_W-1:0] rem_in  [LANES];
      logic [Q_W-1:0]   quo_in  [LANES];

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_num;
         assign den_src = in_den;
         assign sb_src  = in_sb;
         for (genvar l = 0; l < LANES; l++) begin : g_clr
            assign quo_src[l] = '0;
         end
      end else begin : g_next
         assign v_src   = valid_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign sb_src  = sb_ff[s-1];
      end

      // Up to STEPS quotient bits, MSB first
      always_comb begin
         logic [EXT_W-1:0] acc;
         logic [EXT_W-1:0] trial;
         acc   = '0;
         trial = '0;
         for (int l = 0; l < LANES; l++) begin
            acc       = EXT_W'(rem_src[l]);
            quo_in[l] = quo_src[l];
            for (int k = 0; k < STEPS; k++) begin
               if (s * STEPS + k < Q_W) begin
                  trial = EXT_W'(den_src[l]) << (Q_W - 1 - (s * STEPS + k));
                  if (acc >= trial) begin
                     acc = acc - trial;
                     quo_in[l][Q_W-1-(s*STEPS+k)] = 1'b1;
                  end
               end
            end
            rem_in[l] = acc[NUM_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            quo_ff[s] <= quo_in;
            sb_ff[s]  <= sb_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_sb    = sb_ff[STAGES-1];

endmodule

// ----- design/hslp_hue_prep.sv -----
// Two pipeline stages: percent clamp with max/min pick, then hue and
// saturation numerators and divisors. Depends on hslp_pkg.
module hslp_hue_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  logic [hslp_pkg::PCT_W-1:0]            in_pct [3],
   input  hslp_pkg::pct_sb_type                  in_sb,
   output logic                                  out_valid,
   output logic [hslp_pkg::RATIO_NUM_W-1:0]      out_num [2],
   output logic [hslp_pkg::RATIO_DEN_W-1:0]      out_den [2],
   output hslp_pkg::hue_ctl_type                 out_ctl
);

   localparam int PW = hslp_pkg::PCT_W;
   localparam int NW = hslp_pkg::RATIO_NUM_W;
   localparam int DW = hslp_pkg::RATIO_DEN_W;

   // stage A: clamp, max, min
   logic                     a_valid_ff;
   logic [PW-1:0]            a_r_ff, a_g_ff, a_b_ff, a_hi_ff, a_lo_ff;
   hslp_pkg::hue_sector_type a_sect_ff;
   logic                     a_zero_ff;

   logic [PW-1:0]            p_r, p_g, p_b, hi_in, lo_in;
   hslp_pkg::hue_sector_type sect_in;

   always_comb begin
      p_r = (in_sb.ovf[0] || in_pct[0] > PW'(hslp_pkg::PCT_FULL)) ?
            PW'(hslp_pkg::PCT_FULL) : in_pct[0];
      p_g = (in_sb.ovf[1] || in_pct[1] > PW'(hslp_pkg::PCT_FULL)) ?
            PW'(hslp_pkg::PCT_FULL) : in_pct[1];
      p_b = (in_sb.ovf[2] || in_pct[2] > PW'(hslp_pkg::PCT_FULL)) ?
            PW'(hslp_pkg::PCT_FULL) : in_pct[2];
      // ties: red, then green
      if (p_r >= p_g && p_r >= p_b) begin
         hi_in   = p_r;
         sect_in = hslp_pkg::SECT_RED;
      end else if (p_g >= p_b) begin
         hi_in   = p_g;
         sect_in = hslp_pkg::SECT_GREEN;
      end else begin
         hi_in   = p_b;
         sect_in = hslp_pkg::SECT_BLUE;
      end
      lo_in = p_r;
      if (p_g < lo_in) lo_in = p_g;
      if (p_b < lo_in) lo_in = p_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_r_ff    <= p_r;
         a_g_ff    <= p_g;
         a_b_ff    <= p_b;
         a_hi_ff   <= hi_in;
         a_lo_ff   <= lo_in;
         a_sect_ff <= sect_in;
         a_zero_ff <= in_sb.zero;
      end
   end

   // stage B: numerators and divisors
   logic                  b_valid_ff;
   logic [NW-1:0]         b_num_ff [2];
   logic [DW-1:0]         b_den_ff [2];
   hslp_pkg::hue_ctl_type b_ctl_ff;

   logic [PW-1:0]         diff, mag;
   logic [DW-1:0]         sum;
   logic [PW-1:0]         light;
   logic                  neg;
   logic [PW-1:0]         x_a, x_b;
   logic [NW-1:0]         num_in [2];
   logic [DW-1:0]         den_in [2];
   hslp_pkg::hue_ctl_type ctl_in;

   always_comb begin
      diff  = a_hi_ff - a_lo_ff;
      sum   = DW'(a_hi_ff) + DW'(a_lo_ff);
      light = sum[DW-1:1];
      case (a_sect_ff)
         hslp_pkg::SECT_RED: begin
            x_a = a_g_ff;
            x_b = a_b_ff;
         end
         hslp_pkg::SECT_GREEN: begin
            x_a = a_b_ff;
            x_b = a_r_ff;
         end
         default: begin
            x_a = a_r_ff;
            x_b = a_g_ff;
         end
      endcase
      neg       = x_a < x_b;
      mag       = neg ? (x_b - x_a) : (x_a - x_b);
      num_in[0] = NW'(mag) * NW'(hslp_pkg::HUE_STEP);
      den_in[0] = DW'(diff);
      num_in[1] = NW'(diff) * NW'(hslp_pkg::PCT_FULL);
      den_in[1] = (light <= PW'(hslp_pkg::LIGHT_HALF)) ? sum :
                  DW'(hslp_pkg::SUM_FULL) - sum;
      ctl_in.zero      = a_zero_ff;
      ctl_in.grey      = (diff == '0);
      ctl_in.neg       = neg;
      ctl_in.sector    = a_sect_ff;
      ctl_in.lightness = light;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_num_ff <= num_in;
         b_den_ff <= den_in;
         b_ctl_ff <= ctl_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_num   = b_num_ff;
   assign out_den   = b_den_ff;
   assign out_ctl   = b_ctl_ff;

endmodule

// ----- design/rgbc_to_hsl_percent.sv -----
// Top level: color sensor sample (clear, red, green, blue) to hue, saturation, lightness.
// Depends on hslp_pkg, hslp_divider and hslp_hue_prep.
//
// Usage
//   Input channel req_*: one sample per item, taken when req_valid and
//   req_ready are both high. Result channel rsp_*: one result item per
//   sample, in order, taken when rsp_valid and rsp_ready are both high.
//   Throughput: one sample per clock while the output is not blocked;
//   the pipeline is fully registered, with the percent and the
//   hue/saturation division each done by a 4-stage restoring divider,
//   two quotient bits per stage.
//   Stall: the whole pipeline advances together on one enable. While a
//   result waits with rsp_ready low, req_ready is low and every stage
//   holds; nothing is dropped or repeated. Bubbles are not squeezed out.
//   Reset (synchronous, active high) clears all valid bits; in-flight
//   items are discarded. There is no configuration and no state between
//   samples.
//   A zero clear count yields hue, saturation and lightness of zero with
//   rsp_zero_clear set.
module rgbc_to_hsl_percent (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hslp_pkg::CNT_W-1:0]         req_clear_count,
   input  logic [hslp_pkg::CNT_W-1:0]         req_red_count,
   input  logic [hslp_pkg::CNT_W-1:0]         req_green_count,
   input  logic [hslp_pkg::CNT_W-1:0]         req_blue_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hslp_pkg::HUE_W-1:0]         rsp_hue,
   output logic [hslp_pkg::PCT_W-1:0]         rsp_saturation,
   output logic [hslp_pkg::PCT_W-1:0]         rsp_lightness,
   output logic                               rsp_zero_clear
);

   localparam int CW = hslp_pkg::CNT_W;
   localparam int SW = hslp_pkg::SCALED_W;
   localparam int PW = hslp_pkg::PCT_W;
   localparam int HW = hslp_pkg::HUE_W;

   logic enable;

   // one enable for the whole pipe: move unless the output is blocked
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // stage 0: scale each color by 100
   logic          s0_valid_ff;
   logic [SW-1:0] s0_num_ff [3];
   logic [CW-1:0] s0_clear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_num_ff[0] <= SW'(req_red_count)   * SW'(hslp_pkg::PCT_FULL);
         s0_num_ff[1] <= SW'(req_green_count) * SW'(hslp_pkg::PCT_FULL);
         s0_num_ff[2] <= SW'(req_blue_count)  * SW'(hslp_pkg::PCT_FULL);
         s0_clear_ff  <= req_clear_count;
      end
   end

   // stage 1: detect quotients of 128 and up; those saturate anyway
   logic                 s1_valid_ff;
   logic [SW-1:0]        s1_num_ff [3];
   logic [CW-1:0]        s1_den_ff [3];
   hslp_pkg::pct_sb_type s1_sb_ff;
   logic [SW-1:0]        lim;
   logic [2:0]           ovf;

   assign lim = SW'(s0_clear_ff) << PW;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ovf[i] = s0_num_ff[i] >= lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            s1_num_ff[i] <= ovf[i] ? '0 : s0_num_ff[i];
            s1_den_ff[i] <= s0_clear_ff;
         end
         s1_sb_ff.ovf  <= ovf;
         s1_sb_ff.zero <= (s0_clear_ff == '0);
      end
   end

   // percent of clear, 7 quotient bits
   logic                 pct_valid;
   logic [PW-1:0]        pct_quo [3];
   hslp_pkg::pct_sb_type pct_sb;

   hslp_divider #(
      .LANES (3),
      .NUM_W (SW),
      .DEN_W (CW),
      .Q_W   (PW),
      .SB_W  ($bits(hslp_pkg::pct_sb_type)),
      .STEPS (hslp_pkg::DIV_STEPS)
   ) u_pct_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .in_sb     (s1_sb_ff),
      .out_valid (pct_valid),
      .out_quo   (pct_quo),
      .out_sb    (pct_sb)
   );

   // clamp, max/min, hue and saturation operands
   logic                                 prep_valid;
   logic [hslp_pkg::RATIO_NUM_W-1:0]     prep_num [2];
   logic [hslp_pkg::RATIO_DEN_W-1:0]     prep_den [2];
   hslp_pkg::hue_ctl_type                prep_ctl;

   hslp_hue_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (pct_valid),
      .in_pct    (pct_quo),
      .in_sb     (pct_sb),
      .out_valid (prep_valid),
      .out_num   (prep_num),
      .out_den   (prep_den),
      .out_ctl   (prep_ctl)
   );

   // lane 0: hue offset magnitude, lane 1: saturation
   logic                  ratio_valid;
   logic [PW-1:0]         ratio_quo [2];
   hslp_pkg::hue_ctl_type ratio_ctl;

   hslp_divider #(
      .LANES (2),
      .NUM_W (hslp_pkg::RATIO_NUM_W),
      .DEN_W (hslp_pkg::RATIO_DEN_W),
      .Q_W   (PW),
      .SB_W  ($bits(hslp_pkg::hue_ctl_type)),
      .STEPS (hslp_pkg::DIV_STEPS)
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (prep_valid),
      .in_num    (prep_num),
      .in_den    (prep_den),
      .in_sb     (prep_ctl),
      .out_valid (ratio_valid),
      .out_quo   (ratio_quo),
      .out_sb    (ratio_ctl)
   );

   // output stage: place hue in its sector, apply grey and zero-clear
   logic          rsp_valid_ff;
   logic [HW-1:0] hue_ff, hue_in, base, q_ext;
   logic [PW-1:0] sat_ff, sat_in, light_ff, light_in;
   logic          zero_ff;

   always_comb begin
      q_ext = HW'(ratio_quo[0]);
      case (ratio_ctl.sector)
         hslp_pkg::SECT_RED:   base = HW'(hslp_pkg::HUE_FULL);
         hslp_pkg::SECT_GREEN: base = HW'(hslp_pkg::HUE_GREEN);
         default:              base = HW'(hslp_pkg::HUE_BLUE);
      endcase
      // red sector: positive offset stands alone, negative wraps from 360
      if (ratio_ctl.sector == hslp_pkg::SECT_RED && !ratio_ctl.neg) begin
         hue_in = q_ext;
      end else if (ratio_ctl.neg) begin
         hue_in = base - q_ext;
      end else begin
         hue_in = base + q_ext;
      end
      sat_in   = ratio_quo[1];
      light_in = ratio_ctl.lightness;
      if (ratio_ctl.grey) begin
         hue_in = '0;
         sat_in = '0;
      end
      if (ratio_ctl.zero) begin
         hue_in   = '0;
         sat_in   = '0;
         light_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= ratio_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
         zero_ff  <= ratio_ctl.zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = light_ff;
   assign rsp_zero_clear = zero_ff;

endmodule

// ----- design/hslp_checker.sv -----
// Port-level checks for rgbc_to_hsl_percent, bound to the top level.
// Depends on hslp_pkg.
module hslp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hslp_pkg::HUE_W-1:0]    rsp_hue,
   input logic [hslp_pkg::PCT_W-1:0]    rsp_saturation,
   input logic [hslp_pkg::PCT_W-1:0]    rsp_lightness,
   input logic                          rsp_zero_clear
);

   // a blocked result holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue) &&
      $stable(rsp_saturation) && $stable(rsp_lightness) && $stable(rsp_zero_clear))
      else $error("result changed while stalled");

   // a blocked output stalls the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output blocked");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue <= hslp_pkg::HUE_W'(hslp_pkg::HUE_FULL) &&
      rsp_saturation <= hslp_pkg::PCT_W'(hslp_pkg::PCT_FULL) &&
      rsp_lightness <= hslp_pkg::PCT_W'(hslp_pkg::PCT_FULL))
      else $error("result out of range");

   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_clear |-> rsp_hue == '0 && rsp_saturation == '0 &&
      rsp_lightness == '0)
      else $error("zero clear result not forced to zero");

   // right after reset is released no result is valid
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) === 1'b1 && reset === 1'b0 |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind rgbc_to_hsl_percent hslp_checker u_hslp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_lightness  (rsp_lightness),
   .rsp_zero_clear (rsp_zero_clear)
);
